// File: hw/rtl/bta_pkg.sv
package bta_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOMEM  = 2'd1,
        ST_INVARG = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RUN,
        S_MUL,
        S_ADD
    } t_state;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE   = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam int CNT_W = 17;
    localparam int IDX_W = 16;

    // token that travels along the cell row
    typedef struct packed {
        logic             vld;
        logic             free_op;
        logic             hit;
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] idx;
    } t_wave;

endpackage

// File: hw/rtl/block_table_heap_allocator.sv
// First-fit heap allocator over a row of block cells, one cell per heap block, all free
// after reset. BLOCK_BYTES must be a power of two, which the block does not check, so a
// byte size or an address offset turns into blocks with a registered shift; then a token
// walks the cell row one cell a cycle up to the end of the found run, the end of the
// freed chain or the last block in use, and walks back to cell 0; an allocate marks its
// run on the way back, and a free clears its chain on the way out. A successful allocate
// then forms the address in the S_MUL and S_ADD states. A request rejected before the
// scan (a free below the heap base, or a block count or block index out of range)
// answers without a scan. One request is in work at a time, and a new one is taken
// once the previous result word has been taken.
module block_table_heap_allocator #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_free_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_alloc_address,
    output logic [1:0]  o_status
);
    localparam int CW = bta_pkg::CNT_W;
    localparam int IW = bta_pkg::IDX_W;

    logic [31:0]      r_base;
    logic [10:0]      r_bcount;
    logic [CW-1:0]    w_used;

    bta_pkg::t_state  r_state, n_state;
    logic             r_op;
    logic [CW-1:0]    r_need;
    logic [IW-1:0]    r_blk;
    logic [IW-1:0]    r_idx;
    logic [31:0]      r_prod;
    bta_pkg::t_wave   r_launch;
    logic             r_ovalid;
    logic [31:0]      r_addr;
    bta_pkg::t_status r_status;

    logic             w_in_acc, w_bad_free, w_div_start, w_div_done;
    logic [32:0]      w_dividend, w_quot;
    logic             w_q_bad;
    bta_pkg::t_wave   w_fwd [0:MAX_BLOCKS];
    bta_pkg::t_wave   w_bwd [0:MAX_BLOCKS];

    assign w_used = (CW'(r_bcount) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(r_bcount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_bcount <= 11'd1024;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bta_pkg::CFG_HEAP_BASE) begin
                r_base <= i_cfg_data;
            end else begin
                r_bcount <= i_cfg_data[10:0];
            end
        end
    end

    assign o_in_stall  = (r_state != bta_pkg::S_IDLE) || r_ovalid;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_bad_free  = (i_op == bta_pkg::OP_FREE) && (i_free_address < r_base);
    assign w_div_start = w_in_acc && !w_bad_free;
    assign w_dividend  = (i_op == bta_pkg::OP_ALLOC)
                       ? {1'b0, i_size_bytes} + 33'(BLOCK_BYTES - 1)
                       : {1'b0, i_free_address - r_base};

    bta_div #(.DIVISOR(BLOCK_BYTES)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_q_bad = (r_op == bta_pkg::OP_ALLOC)
                   ? (w_quot == '0 || w_quot > 33'(w_used))
                   : (w_quot >= 33'(w_used));

    always_comb begin
        n_state = r_state;
        case (r_state)
            bta_pkg::S_IDLE: if (w_div_start) n_state = bta_pkg::S_DIV;
            bta_pkg::S_DIV: if (w_div_done) n_state = w_q_bad ? bta_pkg::S_IDLE : bta_pkg::S_RUN;
            bta_pkg::S_RUN: begin
                if (w_bwd[0].vld) begin
                    n_state = (w_bwd[0].free_op || !w_bwd[0].hit) ? bta_pkg::S_IDLE
                                                                  : bta_pkg::S_MUL;
                end
            end
            bta_pkg::S_MUL: n_state = bta_pkg::S_ADD;
            bta_pkg::S_ADD: n_state = bta_pkg::S_IDLE;
            default: n_state = bta_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bta_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_launch <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= '0;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            case (r_state)
                bta_pkg::S_IDLE: if (w_in_acc && w_bad_free) r_ovalid <= 1'b1;
                bta_pkg::S_DIV: begin
                    if (w_div_done) begin
                        if (w_q_bad) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            r_launch.vld     <= 1'b1;
                            r_launch.free_op <= r_op;
                            r_launch.cnt     <= CW'(w_quot);
                        end
                    end
                end
                bta_pkg::S_RUN: begin
                    if (w_bwd[0].vld && (w_bwd[0].free_op || !w_bwd[0].hit)) r_ovalid <= 1'b1;
                end
                bta_pkg::S_ADD: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bta_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_op     <= i_op;
                    r_addr   <= '0;
                    r_status <= bta_pkg::ST_INVARG;
                end
            end
            bta_pkg::S_DIV: begin
                if (w_div_done) begin
                    r_need   <= CW'(w_quot);
                    r_blk    <= IW'(w_quot);
                    r_status <= (r_op == bta_pkg::OP_ALLOC) ? bta_pkg::ST_NOMEM
                                                            : bta_pkg::ST_INVARG;
                end
            end
            bta_pkg::S_RUN: begin
                if (w_bwd[0].vld) begin
                    r_idx    <= w_bwd[0].idx;
                    r_status <= (w_bwd[0].hit) ? bta_pkg::ST_OK : bta_pkg::ST_NOMEM;
                end
            end
            bta_pkg::S_MUL: r_prod <= 32'({16'd0, r_idx} * 32'(BLOCK_BYTES));
            bta_pkg::S_ADD: r_addr <= r_base + r_prod;
            default: ;
        endcase
    end

    assign w_fwd[0]          = r_launch;
    assign w_bwd[MAX_BLOCKS] = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        bta_cell #(.INDEX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_fwd   (w_fwd[g]),
            .i_bwd   (w_bwd[g+1]),
            .i_need  (r_need),
            .i_blk   (r_blk),
            .i_used  (w_used),
            .o_fwd   (w_fwd[g+1]),
            .o_bwd   (w_bwd[g])
        );
    end

    assign o_out_valid     = r_ovalid;
    assign o_alloc_address = r_addr;
    assign o_status        = r_status;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != bta_pkg::S_IDLE) || r_ovalid)
        else $error("request lost");
    a_ret_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bwd[0].vld |-> r_state == bta_pkg::S_RUN)
        else $error("token returned outside scan");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fwd[MAX_BLOCKS].vld)
        else $error("token ran off the row");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_status == bta_pkg::ST_OK || r_addr == '0))
        else $error("address on failed request");
endmodule

// File: hw/rtl/bta_div.sv
module bta_div #(
    parameter int DIVISOR = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    output logic        o_done,
    output logic [32:0] o_quot
);
    // divisor is a power of two: the quotient is a shift, registered once
    localparam int SHIFT = $clog2(DIVISOR);

    logic        r_done;
    logic [32:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend >> SHIFT;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: hw/rtl/bta_cell.sv
module bta_cell #(
    parameter int INDEX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bta_pkg::t_wave           i_fwd,
    input  bta_pkg::t_wave           i_bwd,
    input  logic [bta_pkg::CNT_W-1:0] i_need,
    input  logic [bta_pkg::IDX_W-1:0] i_blk,
    input  logic [bta_pkg::CNT_W-1:0] i_used,
    output bta_pkg::t_wave           o_fwd,
    output bta_pkg::t_wave           o_bwd
);
    logic           r_taken, r_next;
    logic           n_taken, n_next;
    bta_pkg::t_wave r_fwd, r_bwd, n_fwd, n_bwd;
    logic           w_last;

    assign w_last = (bta_pkg::CNT_W'(INDEX + 1) == i_used);

    always_comb begin
        n_taken = r_taken;
        n_next  = r_next;
        n_fwd   = '0;
        n_bwd   = '0;
        if (i_fwd.vld) begin
            if (!i_fwd.free_op) begin
                if (!r_taken && i_fwd.cnt == bta_pkg::CNT_W'(1)) begin
                    n_taken   = 1'b1;
                    n_next    = 1'b0;
                    n_bwd.vld = 1'b1;
                    n_bwd.hit = 1'b1;
                    n_bwd.cnt = i_need - bta_pkg::CNT_W'(1);
                    n_bwd.idx = bta_pkg::IDX_W'(INDEX);
                end else if (w_last) begin
                    n_bwd.vld = 1'b1;
                end else begin
                    n_fwd     = i_fwd;
                    n_fwd.cnt = r_taken ? i_need : i_fwd.cnt - bta_pkg::CNT_W'(1);
                end
            end else if (i_fwd.hit || i_blk == bta_pkg::IDX_W'(INDEX)) begin
                n_taken = 1'b0;
                n_next  = 1'b0;
                if (!r_next || w_last) begin
                    n_bwd         = i_fwd;
                    n_bwd.hit     = 1'b1;
                end else begin
                    n_fwd     = i_fwd;
                    n_fwd.hit = 1'b1;
                end
            end else begin
                n_fwd = i_fwd;
            end
        end else if (i_bwd.vld) begin
            n_bwd = i_bwd;
            if (!i_bwd.free_op && i_bwd.cnt != '0) begin
                n_taken   = 1'b1;
                n_next    = 1'b1;
                n_bwd.cnt = i_bwd.cnt - bta_pkg::CNT_W'(1);
                if (i_bwd.cnt == bta_pkg::CNT_W'(1)) begin
                    n_bwd.idx = bta_pkg::IDX_W'(INDEX);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
            r_next  <= 1'b0;
            r_fwd   <= '0;
            r_bwd   <= '0;
        end else begin
            r_taken <= n_taken;
            r_next  <= n_next;
            r_fwd   <= n_fwd;
            r_bwd   <= n_bwd;
        end
    end

    assign o_fwd = r_fwd;
    assign o_bwd = r_bwd;
endmodule

// File: test/bta_checker.sv
module bta_checker #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_free_address,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_alloc_address,
    input  logic [1:0]  i_status,
    output int          o_fails,
    output int          o_due,
    output int          o_checked
);

    localparam int F_TAKEN = 0;
    localparam int F_NEXT  = 1;
    localparam int F_FIRST = 2;

    typedef struct packed {
        logic [31:0]      addr;
        bta_pkg::t_status st;
    } t_answer;

    logic [2:0]  blk_flags [MAX_BLOCKS];
    logic [31:0] heap_base_q;
    logic [10:0] block_count_q;
    t_answer     answers_due [$];

    // first-fit allocate / chain free against the shadow block table
    function automatic t_answer heap_answer(logic op, logic [31:0] size, logic [31:0] addr);
        longint unsigned need;
        longint unsigned used;
        longint unsigned blk;
        logic [31:0]     diff;
        int              run;
        int              start;
        bit              found;
        logic [2:0]      e;
        t_answer         a;
        a.addr = '0;
        a.st   = bta_pkg::ST_OK;
        used   = (block_count_q > MAX_BLOCKS) ? MAX_BLOCKS : block_count_q;
        if (op == bta_pkg::OP_ALLOC) begin
            need  = size;
            need  = (need + BLOCK_BYTES - 1) / BLOCK_BYTES;
            found = 0;
            run   = 0;
            start = 0;
            if (need != 0 && need <= used) begin
                for (int i = 0; i < used && !found; i++) begin
                    if (blk_flags[i][F_TAKEN]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == need) begin
                            start = i + 1 - run;
                            found = 1;
                        end
                    end
                end
            end
            if (!found) begin
                a.st = bta_pkg::ST_NOMEM;
            end else begin
                for (int i = start; i < start + need; i++) begin
                    e = '0;
                    e[F_TAKEN] = 1'b1;
                    e[F_FIRST] = (i == start);
                    e[F_NEXT]  = (i != start + need - 1);
                    blk_flags[i] = e;
                end
                a.addr = heap_base_q + 32'(start * BLOCK_BYTES);
            end
        end else begin
            if (addr < heap_base_q) begin
                a.st = bta_pkg::ST_INVARG;
            end else begin
                diff = addr - heap_base_q;
                blk  = diff / BLOCK_BYTES;
                if (blk >= used) begin
                    a.st = bta_pkg::ST_INVARG;
                end else begin
                    for (int i = int'(blk); i < used; i++) begin
                        e = blk_flags[i];
                        blk_flags[i] = '0;
                        if (!e[F_NEXT]) break;
                    end
                end
            end
        end
        return a;
    endfunction

    task automatic note_fail(string msg);
        o_fails++;
        if (o_fails <= 10) $display("mismatch: %s", msg);
    endtask

    initial begin
        o_fails   = 0;
        o_due     = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        t_answer exp_w;
        if (!i_rst_n) begin
            foreach (blk_flags[i]) blk_flags[i] = '0;
            heap_base_q   = '0;
            block_count_q = 11'd1024;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bta_pkg::CFG_HEAP_BASE) heap_base_q = i_cfg_data;
                else block_count_q = i_cfg_data[10:0];
            end
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (answers_due.size() == 0) begin
                    note_fail($sformatf("unexpected word addr=%h status=%0d",
                        i_alloc_address, i_status));
                end else begin
                    exp_w = answers_due.pop_front();
                    if (i_alloc_address !== exp_w.addr || i_status !== exp_w.st)
                        note_fail($sformatf("addr exp %h got %h, status exp %0d got %0d",
                            exp_w.addr, i_alloc_address, exp_w.st, i_status));
                end
            end
            if (i_in_valid && !i_in_stall)
                answers_due.push_back(heap_answer(i_op, i_size_bytes, i_free_address));
        end
        o_due = answers_due.size();
    end

endmodule

// File: test/tb.sv
module tb;

    localparam int BLK      = 4096;
    localparam int NBLK     = 1024;
    localparam int WD_LIMIT = 30000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_op;
    logic [31:0] i_size_bytes;
    logic [31:0] i_free_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_alloc_address;
    logic [1:0]  o_status;

    int          fails;
    int          due;
    int          checked;
    int          sent;
    int          settings;
    int          idle_cycles;
    int          out_hold;
    bit          calm;
    logic        ops_sent [$];
    logic [31:0] live [$];
    logic [31:0] cur_base;
    int          cur_count;

    block_table_heap_allocator #(.MAX_BLOCKS(NBLK), .BLOCK_BYTES(BLK)) i_dut (.*);

    bta_checker #(.MAX_BLOCKS(NBLK), .BLOCK_BYTES(BLK)) i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_op(i_op), .i_size_bytes(i_size_bytes), .i_free_address(i_free_address),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_alloc_address(o_alloc_address), .i_status(o_status),
        .o_fails(fails), .o_due(due), .o_checked(checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side stall and tracking of live allocations for the stimulus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (ops_sent.size() > 0 && ops_sent.pop_front() == bta_pkg::OP_ALLOC
                    && o_status == bta_pkg::ST_OK)
                live.push_back(o_alloc_address);
            out_hold = calm ? 0 : $urandom_range(0, 12);
            i_out_stall <= (out_hold != 0);
        end else if (o_out_valid) begin
            if (out_hold > 0) out_hold--;
            i_out_stall <= (out_hold != 0);
        end
        if (i_in_valid && !o_in_stall) ops_sent.push_back(i_op);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(logic op, logic [31:0] size, logic [31:0] addr);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_size_bytes   <= size;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic set_heap(logic [31:0] base, int count);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bta_pkg::CFG_HEAP_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= bta_pkg::CFG_BLOCK_COUNT;
        i_cfg_data <= 32'(count);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_base  = base;
        cur_count = count;
        settings++;
    endtask

    task automatic random_item();
        int          r;
        int          k;
        int          nb;
        logic [31:0] a;
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 75 && live.size() == 0)) begin
            nb = $urandom_range(1, (cur_count < 8) ? cur_count : 8);
            send(bta_pkg::OP_ALLOC, 32'((nb - 1) * BLK + $urandom_range(1, BLK)), $urandom());
        end else if (r < 75) begin
            k = $urandom_range(0, live.size() - 1);
            a = live[k];
            live.delete(k);
            if ($urandom_range(0, 3) == 0) a = a + $urandom_range(0, BLK - 1);
            send(bta_pkg::OP_FREE, $urandom(), a);
        end else if (r < 85) begin
            send(bta_pkg::OP_ALLOC,
                ($urandom_range(0, 1) != 0) ? $urandom() : 32'($urandom_range(0, 3)),
                $urandom());
        end else begin
            a = ($urandom_range(0, 1) != 0) ? $urandom()
                : cur_base + 32'($urandom_range(0, cur_count + 2) * BLK);
            send(bta_pkg::OP_FREE, $urandom(), a);
        end
    endtask

    initial begin
        int counts [8] = '{1, 2, 5, 8, 16, 33, 64, 1024};
        int n;
        sent        = 0;
        settings    = 1;
        calm        = 0;
        cur_base    = '0;
        cur_count   = NBLK;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = bta_pkg::CFG_HEAP_BASE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_op        = bta_pkg::OP_ALLOC;
        i_size_bytes   = '0;
        i_free_address = '0;
        i_out_stall = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: base 0, full table
        send(bta_pkg::OP_ALLOC, 32'd0, 32'd0);
        send(bta_pkg::OP_ALLOC, 32'd1, 32'd0);
        send(bta_pkg::OP_ALLOC, 32'd4096, 32'd0);
        send(bta_pkg::OP_ALLOC, 32'd4097, 32'hffffffff);
        send(bta_pkg::OP_ALLOC, 32'hffffffff, 32'd0);
        send(bta_pkg::OP_FREE, 32'hffffffff, 32'h0000_1005);
        send(bta_pkg::OP_FREE, 32'd0, 32'h0000_1000);
        send(bta_pkg::OP_FREE, 32'd0, 32'h0000_3000);
        send(bta_pkg::OP_FREE, 32'd0, 32'hffffffff);
        send(bta_pkg::OP_ALLOC, 32'(1020 * BLK), 32'd0);
        send(bta_pkg::OP_FREE, 32'd0, 32'd0);

        // tiny heap: trailing short run, mid-chain free
        set_heap(32'h1000_0000, 4);
        send(bta_pkg::OP_FREE, 32'd0, 32'h0fff_ffff);
        send(bta_pkg::OP_ALLOC, 32'(3 * BLK), 32'd0);
        send(bta_pkg::OP_ALLOC, 32'(2 * BLK), 32'd0);
        send(bta_pkg::OP_ALLOC, 32'd100, 32'd0);
        send(bta_pkg::OP_ALLOC, 32'd100, 32'd0);
        send(bta_pkg::OP_FREE, 32'd0, 32'h1000_1000);
        send(bta_pkg::OP_ALLOC, 32'(2 * BLK), 32'd0);
        send(bta_pkg::OP_FREE, 32'd0, 32'h1000_4000);

        // top of address space: wrapping allocate address
        set_heap(32'hffff_f000, 2);
        send(bta_pkg::OP_ALLOC, 32'd1, 32'd0);
        send(bta_pkg::OP_ALLOC, 32'd1, 32'd0);
        send(bta_pkg::OP_FREE, 32'd0, 32'd0);
        send(bta_pkg::OP_FREE, 32'd0, 32'hffff_f000);

        for (int p = 0; p < 8; p++) begin
            calm = (p % 3 == 1);
            case (p)
                0: set_heap(32'h0, counts[p]);
                7: set_heap(32'hffff_f000, counts[p]);
                default: set_heap({$urandom_range(0, 32'hfffff), 12'h0}, counts[p]);
            endcase
            n = (p == 7) ? 40 : 68;
            for (int i = 0; i < n; i++) random_item();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
        repeat (2 * NBLK + 60) @(posedge i_clk);
        $display("covered %0d requests over %0d heap settings, %0d result words checked",
            sent, settings, checked);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", fails);
            $display("FAIL");
        end
        $finish;
    end

endmodule
